@@ hdl/hsv_to_rgb_converter_top_assert.svh @@
// Assertion macros for the HSV to RGB converter checker.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH

// Clocked check, dropped while reset is asserted.
`define HSV2RGB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define HSV2RGB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/hsv2rgb_pkg.sv @@
// Shared types, constants and functions of the HSV to RGB converter.
// No dependencies; used by the top level, the channel pipeline and the checker.
package hsv2rgb_pkg;

	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned PIPE_DEPTH = 5;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [2:0] seg;
		logic [5:0] prog;
	} hue_pos_t;

	// Corner colors, bit 2 red, bit 1 green, bit 0 blue; a set bit is 255.
	// The last two entries keep the hue segment past the last corner at red.
	localparam logic [2:0] CORNER_RGB [8] = '{
		3'b100, 3'b101, 3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b100
	};

	// Split hue into a 42-step segment and the position inside it.
	function automatic hue_pos_t hue_split(input logic [7:0] hue);
		hue_pos_t   pos;
		logic [7:0] base;
		if (hue >= 8'd252) begin
			pos.seg = 3'd6; base = 8'd252;
		end else if (hue >= 8'd210) begin
			pos.seg = 3'd5; base = 8'd210;
		end else if (hue >= 8'd168) begin
			pos.seg = 3'd4; base = 8'd168;
		end else if (hue >= 8'd126) begin
			pos.seg = 3'd3; base = 8'd126;
		end else if (hue >= 8'd84) begin
			pos.seg = 3'd2; base = 8'd84;
		end else if (hue >= 8'd42) begin
			pos.seg = 3'd1; base = 8'd42;
		end else begin
			pos.seg = 3'd0; base = 8'd0;
		end
		pos.prog = 6'(hue - base);
		return pos;
	endfunction

	// floor(k * 255 / 42) for k in 0..42, as 6k + floor(k / 14).
	function automatic logic [7:0] hue_ramp(input logic [5:0] k);
		logic [7:0] frac;
		if (k >= 6'd42)
			frac = 8'd3;
		else if (k >= 6'd28)
			frac = 8'd2;
		else if (k >= 6'd14)
			frac = 8'd1;
		else
			frac = 8'd0;
		return ({2'b00, k} * 8'd6) + frac;
	endfunction

	// Interpolate the three channels between the two corners of the segment.
	function automatic rgb_t hue_color(input logic [7:0] hue);
		hue_pos_t         pos;
		logic [2:0]       lo;
		logic [2:0]       hi;
		logic [2:0][7:0]  chans;
		pos = hue_split(hue);
		lo  = CORNER_RGB[pos.seg];
		hi  = CORNER_RGB[3'(pos.seg + 3'd1)];
		for (int ch = 0; ch < 3; ch++) begin
			if (lo[ch] && hi[ch])
				chans[ch] = 8'hFF;
			else if (!lo[ch] && !hi[ch])
				chans[ch] = 8'h00;
			else if (lo[ch])
				chans[ch] = hue_ramp(6'(6'd42 - pos.prog));
			else
				chans[ch] = hue_ramp(pos.prog);
		end
		return rgb_t'(chans);
	endfunction

	// floor(x / 255), exact for x up to 255 * 255.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return s[15:8];
	endfunction

endpackage

@@ hdl/hsv2rgb_chan.sv @@
// Saturation and value pipeline for one color channel, stages 2 to 5.
// Depends on hsv2rgb_pkg for div255.
module hsv2rgb_chan
	import hsv2rgb_pkg::*;
(
	input  logic              clk,
	input  logic [CHAN_W-1:0] chan_s1,
	input  logic [CHAN_W-1:0] sat_s1,
	input  logic [CHAN_W-1:0] val_s1,
	output logic [CHAN_W-1:0] chan_s5
);

	logic [15:0]       mix_s2;
	logic [CHAN_W-1:0] val_s2;
	logic [CHAN_W-1:0] lift_s3;
	logic [CHAN_W-1:0] val_s3;
	logic [15:0]       scale_s4;
	logic [CHAN_W-1:0] inv_sat;
	logic [CHAN_W-1:0] inv_val;

	assign inv_sat = 8'hFF - sat_s1;
	assign inv_val = 8'hFF - val_s3;

	always_ff @(posedge clk) begin
		// 255*sat + c*(255-sat), at most 65025
		mix_s2   <= ({sat_s1, 8'h00} - {8'h00, sat_s1}) + (16'(chan_s1) * 16'(inv_sat));
		val_s2   <= val_s1;
		lift_s3  <= div255(mix_s2);
		val_s3   <= val_s2;
		scale_s4 <= 16'(inv_val) * 16'(lift_s3);
		chan_s5  <= div255(scale_s4);
	end

endmodule

@@ hdl/hsv_to_rgb_converter_top.sv @@
// HSV to RGB converter, top level: hue stage and three channel pipelines.
// Depends on hsv2rgb_pkg and hsv2rgb_chan.

// One pixel enters on every clock where start is high; busy never rises, so
// a new transaction may follow each cycle with no gaps. Each result appears on
// red_out, green_out and blue_out with done high for exactly one cycle once its
// start has passed the pipeline: one stage maps hue to a corner blend, then two
// multiply and divide-by-255 pairs apply saturation and value, each split over
// two register stages. The receiver cannot stall; results must be taken as
// they come. Saturation blends toward 255 and value scales by 255 minus value.
module hsv_to_rgb_converter_top
	import hsv2rgb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CHAN_W-1:0] hue_in,
	input  logic [CHAN_W-1:0] sat_in,
	input  logic [CHAN_W-1:0] val_in,
	output logic              done,
	output logic [CHAN_W-1:0] red_out,
	output logic [CHAN_W-1:0] green_out,
	output logic [CHAN_W-1:0] blue_out
);

	logic [PIPE_DEPTH-1:0] valid_q;
	rgb_t                  color_s1;
	logic [CHAN_W-1:0]     sat_s1;
	logic [CHAN_W-1:0]     val_s1;

	assign busy = 1'b0;

	// Advance valid bits with the data; bit i marks stage i+1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[PIPE_DEPTH-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		color_s1 <= hue_color(hue_in);
		sat_s1   <= sat_in;
		val_s1   <= val_in;
	end

	hsv2rgb_chan u_red (
		.clk     (clk),
		.chan_s1 (color_s1.red),
		.sat_s1  (sat_s1),
		.val_s1  (val_s1),
		.chan_s5 (red_out)
	);

	hsv2rgb_chan u_green (
		.clk     (clk),
		.chan_s1 (color_s1.green),
		.sat_s1  (sat_s1),
		.val_s1  (val_s1),
		.chan_s5 (green_out)
	);

	hsv2rgb_chan u_blue (
		.clk     (clk),
		.chan_s1 (color_s1.blue),
		.sat_s1  (sat_s1),
		.val_s1  (val_s1),
		.chan_s5 (blue_out)
	);

	assign done = valid_q[PIPE_DEPTH-1];

endmodule

@@ hdl/hsv2rgb_checker.sv @@
// Port-level checker for the HSV to RGB converter, bound to the top level.
// Depends on hsv2rgb_pkg and the assertion macros header.
`include "hsv_to_rgb_converter_top_assert.svh"

module hsv2rgb_checker
	import hsv2rgb_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [CHAN_W-1:0] hue_in,
	input logic [CHAN_W-1:0] sat_in,
	input logic [CHAN_W-1:0] val_in,
	input logic              done,
	input logic [CHAN_W-1:0] red_out,
	input logic [CHAN_W-1:0] green_out,
	input logic [CHAN_W-1:0] blue_out
);

	logic in_take;
	logic full_val;
	logic top_hue;
	logic is_black;
	logic is_red;

	assign in_take  = start && !busy;
	assign full_val = in_take && val_in == 8'hFF;
	assign top_hue  = in_take && hue_in >= 8'd252 && sat_in == 8'h00 && val_in == 8'h00;
	assign is_black = red_out == 8'h00 && green_out == 8'h00 && blue_out == 8'h00;
	assign is_red   = red_out == 8'hFF && green_out == 8'h00 && blue_out == 8'h00;

	`HSV2RGB_ASSERT_ALWAYS(a_never_busy, !busy, "converter stalled its input")
	`HSV2RGB_ASSERT(a_latency, in_take |-> ##5 done, "result missing five cycles after start")
	`HSV2RGB_ASSERT(a_no_phantom, done |-> $past(in_take, 5), "result without a matching start")
	`HSV2RGB_ASSERT(a_full_value_black, full_val |-> ##5 is_black, "full value must give black")
	`HSV2RGB_ASSERT(a_top_hue_red, top_hue |-> ##5 is_red, "top hues must give pure red")

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_hsv2rgb_checker (.*);
